// ===== sv/plpt_pkg.sv =====
package plpt_pkg;

  // resolution register width, fixed by the register map
  localparam int unsigned RES_W = 40;
  localparam logic [RES_W-1:0] RES_RESET = 40'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ,
    ST_ROOT,
    ST_ACC,
    ST_CMP
  } state_e;

endpackage

// ===== sv/path_length_point_thinning.sv =====
// Path-length point thinning. Each point (three signed fixed-point coordinates) is compared
// with the previous one; the floor square root of the squared step is added to a saturating
// path-length accumulator, and the point is passed on when the accumulator reaches the
// resolution register, which then clears the accumulator. The first point after reset is
// always passed on. Points are worked on one at a time: a new point is accepted only after
// the bit-serial sum of squares and then the bit-pair serial square root are through with
// the last one; the first point skips both and goes straight to the compare. A kept point
// sits in an output register, so a new point is accepted while it waits to be taken; a
// point that is itself kept waits in its last cycle until that register is free.
// The resolution register has reset value 1.0; cfg_ready_o is high only while the block
// is idle, and a pending write holds off new points.
module path_length_point_thinning #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned ACCUM_WIDTH = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] kept_x_o,
  output logic signed [COORD_WIDTH-1:0] kept_y_o,
  output logic signed [COORD_WIDTH-1:0] kept_z_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [plpt_pkg::RES_W-1:0]    cfg_data_i
);

  localparam int unsigned SQ_W   = 2 * COORD_WIDTH + 2;
  localparam int unsigned ROOT_W = COORD_WIDTH + 1;
  localparam int unsigned SUM_W  = ((ACCUM_WIDTH > ROOT_W) ? ACCUM_WIDTH : ROOT_W) + 1;

  plpt_pkg::state_e state_q, state_d;

  logic                       have_last_q, first_q;
  logic [COORD_WIDTH-1:0]     cur_x_q, cur_y_q, cur_z_q;
  logic [COORD_WIDTH-1:0]     last_x_q, last_y_q, last_z_q;
  logic [COORD_WIDTH-1:0]     dx_q, dy_q, dz_q;
  logic [ACCUM_WIDTH-1:0]     accum_q, res_cmp;
  logic [plpt_pkg::RES_W-1:0] resolution_q;
  logic                       out_valid_q;
  logic [COORD_WIDTH-1:0]     kept_x_q, kept_y_q, kept_z_q;

  logic              accept, out_free, emit, load_out;
  logic              sq_start, sq_done, rt_start, rt_done;
  logic [SQ_W-1:0]   sq;
  logic [ROOT_W-1:0] root;
  logic [SUM_W-1:0]  path_sum;
  logic              sat;

  function automatic logic [COORD_WIDTH-1:0] abs_diff(input logic [COORD_WIDTH-1:0] a,
                                                      input logic [COORD_WIDTH-1:0] b);
    if ($signed(a) > $signed(b)) return a - b;
    else return b - a;
  endfunction

  assign in_stall_o  = (state_q != plpt_pkg::ST_IDLE) || cfg_valid_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = (state_q == plpt_pkg::ST_IDLE);

  // resolution is compared at the accumulator width
  assign res_cmp  = ACCUM_WIDTH'(resolution_q);
  assign emit     = first_q || (accum_q >= res_cmp);
  assign path_sum = SUM_W'(accum_q) + SUM_W'(root);
  assign sat      = |path_sum[SUM_W-1:ACCUM_WIDTH];

  plpt_sqsum #(
    .WIDTH(COORD_WIDTH)
  ) u_sqsum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .op_x_i (dx_q),
    .op_y_i (dy_q),
    .op_z_i (dz_q),
    .done_o (sq_done),
    .sq_o   (sq)
  );

  plpt_isqrt #(
    .RAD_WIDTH(SQ_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(rt_start),
    .rad_i  (sq),
    .done_o (rt_done),
    .root_o (root)
  );

  always_comb begin
    state_d  = state_q;
    sq_start = 1'b0;
    rt_start = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      plpt_pkg::ST_IDLE: begin
        if (accept) state_d = plpt_pkg::ST_DIFF;
      end
      plpt_pkg::ST_DIFF: begin
        if (first_q) begin
          state_d = plpt_pkg::ST_CMP;
        end else begin
          sq_start = 1'b1;
          state_d  = plpt_pkg::ST_SQ;
        end
      end
      plpt_pkg::ST_SQ: begin
        if (sq_done) begin
          rt_start = 1'b1;
          state_d  = plpt_pkg::ST_ROOT;
        end
      end
      plpt_pkg::ST_ROOT: begin
        if (rt_done) state_d = plpt_pkg::ST_ACC;
      end
      plpt_pkg::ST_ACC: begin
        state_d = plpt_pkg::ST_CMP;
      end
      plpt_pkg::ST_CMP: begin
        if (!emit) begin
          state_d = plpt_pkg::ST_IDLE;
        end else if (out_free) begin
          load_out = 1'b1;
          state_d  = plpt_pkg::ST_IDLE;
        end
      end
      default: state_d = plpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= plpt_pkg::ST_IDLE;
      have_last_q  <= 1'b0;
      first_q      <= 1'b0;
      accum_q      <= '0;
      out_valid_q  <= 1'b0;
      resolution_q <= plpt_pkg::RES_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
      if (accept) begin
        first_q     <= !have_last_q;
        have_last_q <= 1'b1;
      end
      if (state_q == plpt_pkg::ST_ACC) begin
        accum_q <= sat ? '1 : path_sum[ACCUM_WIDTH-1:0];
      end else if (load_out) begin
        accum_q <= '0;
      end
      if (cfg_valid_i && cfg_ready_o) resolution_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    // previous point moves on for every point, kept or dropped
    if (accept) begin
      cur_x_q  <= pos_x_i;
      cur_y_q  <= pos_y_i;
      cur_z_q  <= pos_z_i;
      dx_q     <= abs_diff(pos_x_i, last_x_q);
      dy_q     <= abs_diff(pos_y_i, last_y_q);
      dz_q     <= abs_diff(pos_z_i, last_z_q);
      last_x_q <= pos_x_i;
      last_y_q <= pos_y_i;
      last_z_q <= pos_z_i;
    end
    if (load_out) begin
      kept_x_q <= cur_x_q;
      kept_y_q <= cur_y_q;
      kept_z_q <= cur_z_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kept_x_o    = kept_x_q;
  assign kept_y_o    = kept_y_q;
  assign kept_z_o    = kept_z_q;

endmodule

// ===== sv/plpt_sqsum.sv =====
module plpt_sqsum #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WIDTH-1:0]     op_x_i,
  input  logic [WIDTH-1:0]     op_y_i,
  input  logic [WIDTH-1:0]     op_z_i,
  output logic                 done_o,
  output logic [2*WIDTH+1:0]   sq_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam int unsigned SW    = WIDTH + 3;

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [WIDTH-1:0] mx_q, my_q, mz_q;
  logic [WIDTH+1:0] hi_q;
  logic [WIDTH-1:0] lo_q;
  logic [SW-1:0]    pp_sum;

  // serial-parallel multiply: one multiplier bit of each axis per cycle,
  // the operands stay put on the inputs while busy
  assign pp_sum = SW'(hi_q)
                + SW'(mx_q[0] ? op_x_i : '0)
                + SW'(my_q[0] ? op_y_i : '0)
                + SW'(mz_q[0] ? op_z_i : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(WIDTH - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mx_q <= op_x_i;
      my_q <= op_y_i;
      mz_q <= op_z_i;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      mx_q <= mx_q >> 1;
      my_q <= my_q >> 1;
      mz_q <= mz_q >> 1;
      hi_q <= pp_sum[SW-1:1];
      lo_q <= {pp_sum[0], lo_q[WIDTH-1:1]};
    end
  end

  assign done_o = done_q;
  assign sq_o   = {hi_q, lo_q};

endmodule

// ===== sv/plpt_isqrt.sv =====
module plpt_isqrt #(
  parameter int unsigned RAD_WIDTH = 66
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [RAD_WIDTH-1:0]   rad_i,
  output logic                   done_o,
  output logic [RAD_WIDTH/2-1:0] root_o
);

  localparam int unsigned QW    = RAD_WIDTH / 2;
  localparam int unsigned CNT_W = $clog2(QW);

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [RAD_WIDTH-1:0] rad_q;
  logic [QW:0]          rem_q;
  logic [QW-1:0]        root_q;
  logic [QW+2:0]        rem_sh;
  logic [QW+1:0]        trial;
  logic [QW+3:0]        diff;
  logic                 fits;

  // restoring square root, one radicand digit pair per cycle from the top
  assign rem_sh = {rem_q, rad_q[RAD_WIDTH-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign diff   = {1'b0, rem_sh} - {2'b00, trial};
  assign fits   = !diff[QW+3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? diff[QW:0] : rem_sh[QW:0];
      root_q <= {root_q[QW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== sv/plpt_checker.sv =====
module plpt_checker #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [COORD_WIDTH-1:0] kept_x_o,
  input logic [COORD_WIDTH-1:0] kept_y_o,
  input logic [COORD_WIDTH-1:0] kept_z_o
);

  // a point keeps the input stalled after its transfer while it occupies the block
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o ##1 in_stall_o)
    else $error("input taken again too soon after a transfer");

  // a new result only appears while a point is being worked on
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no point in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(kept_x_o)
      && $stable(kept_y_o) && $stable(kept_z_o))
    else $error("stalled result dropped or changed");

  a_out_idle_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind path_length_point_thinning plpt_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_plpt_checker (.*);
